[rtl/core/swm_pkg.sv]
// Shared types and constants for the sliding window median unit.
`timescale 1ns / 1ps
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WS_W     = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [WS_W-1:0]            t_win_size;

    // Register index, taken from paddr bit 2.
    typedef enum logic [0:0] {
        REG_WINDOW_SIZE = 1'b0
    } t_reg_idx;

    localparam t_win_size WS_RESET = 5'd16;

    // Link handed from one cell to its right neighbor.
    typedef struct packed {
        logic    del;   // this cell or one to its left drops its entry
        logic    gt;    // entry after the drop lies above the new item (or is empty)
        t_sample data;  // entry after the drop
    } t_link;

endpackage

[rtl/core/swm_if.sv]
// Valid/ready channels for samples in and medians out.
`timescale 1ns / 1ps
interface swm_smp_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    restart;

    modport source (output valid, sample, restart, input ready);
    modport sink   (input valid, sample, restart, output ready);
endinterface

interface swm_med_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample median;

    modport source (output valid, median, input ready);
    modport sink   (input valid, median, output ready);
endinterface

[rtl/core/sliding_window_median_unit.sv]
// Running median filter: a row of sorted cells plus an output stage.
// Path: the cell row updates on accept, then the median register loads, then the median is valid.
// Throughput: one item per cycle while the output is not stalled; the cell row updates on each accepted sample.
// The output register lets the next sample enter while a median waits to be taken.
// Reset: window size returns to 16, the window is emptied, no item in flight.
// Cell contents need no clearing; only entries below the fill count are used.
`timescale 1ns / 1ps
module sliding_window_median_unit import swm_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swm_smp_if.sink           i_smp,
    swm_med_if.source         o_med,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EXT_W = (CNT_W > WS_W) ? CNT_W : WS_W;

    t_win_size        r_ws;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_pend, n_pend;
    logic             r_ovld, n_ovld;

    logic [EXT_W-1:0] ws_x, w_x;
    logic [CNT_W-1:0] win, fill_eff, cnt;
    logic [AGE_W-1:0] tgt;
    logic             remove, acc, out_load, cfg_wr;

    t_link            links [MAX_WINDOW+1];
    logic [AGE_W-1:0] ages  [MAX_WINDOW+1];
    t_sample [MAX_WINDOW-1:0] vals;
    logic [AGE_W-1:0] cur_ages [MAX_WINDOW];

    // window size: zero acts as one, above the cell count saturates
    always_comb begin
        ws_x = EXT_W'(r_ws);
        if (ws_x == '0) begin
            w_x = EXT_W'(1);
        end else if (ws_x > EXT_W'(MAX_WINDOW)) begin
            w_x = EXT_W'(MAX_WINDOW);
        end else begin
            w_x = ws_x;
        end
        win = CNT_W'(w_x);
        tgt = AGE_W'(win - CNT_W'(1));
    end

    always_comb begin
        acc      = i_smp.valid && i_smp.ready;
        fill_eff = i_smp.restart ? '0 : r_fill;
        remove   = (fill_eff == win);
        cnt      = remove ? fill_eff - CNT_W'(1) : fill_eff;
        out_load = r_pend && (!r_ovld || o_med.ready);
        cfg_wr   = psel && penable && pwrite && pready
                   && (t_reg_idx'(paddr[2]) == REG_WINDOW_SIZE);
    end

    always_comb begin
        n_fill = r_fill;
        if (cfg_wr) begin
            n_fill = '0;
        end else if (acc) begin
            n_fill = cnt + CNT_W'(1);
        end
        if (acc) begin
            n_pend = 1'b1;
        end else if (out_load) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
        if (out_load) begin
            n_ovld = 1'b1;
        end else if (o_med.ready) begin
            n_ovld = 1'b0;
        end else begin
            n_ovld = r_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= WS_RESET;
            r_fill <= '0;
            r_pend <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_ws <= pwdata[WS_W-1:0];
            end
            r_fill <= n_fill;
            r_pend <= n_pend;
            r_ovld <= n_ovld;
        end
    end

    assign links[0] = '{del: 1'b0, gt: 1'b0, data: '0};
    assign ages[0]  = '0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_sample          right_data;
        logic [AGE_W-1:0] right_age;

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_data = '0;
            assign right_age  = '0;
        end else begin : g_mid
            assign right_data = vals[g+1];
            assign right_age  = cur_ages[g+1];
        end

        swm_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_upd        (acc),
            .i_sample     (i_smp.sample),
            .i_fill       (fill_eff),
            .i_cnt        (cnt),
            .i_remove     (remove),
            .i_tgt        (tgt),
            .i_left       (links[g]),
            .i_left_age   (ages[g]),
            .i_right_data (right_data),
            .i_right_age  (right_age),
            .o_link       (links[g+1]),
            .o_age        (ages[g+1]),
            .o_cur_age    (cur_ages[g]),
            .o_data       (vals[g])
        );
    end

    swm_median #(
        .MAX_WINDOW (MAX_WINDOW),
        .CNT_W      (CNT_W)
    ) u_median (
        .i_clk    (i_clk),
        .i_load   (out_load),
        .i_vals   (vals),
        .i_fill   (r_fill),
        .o_median (o_med.median)
    );

    assign i_smp.ready = !r_pend || out_load;
    assign o_med.valid = r_ovld;

    assign pready = 1'b1;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_WINDOW_SIZE)
                    ? APB_DW'(r_ws) : '0;

endmodule

[rtl/core/swm_cell.sv]
// One cell of the sorted window: holds an entry and its age, shifts with neighbors.
`timescale 1ns / 1ps
module swm_cell import swm_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int AGE_W = 4
) (
    input  logic             i_clk,
    input  logic             i_upd,
    input  t_sample          i_sample,
    input  logic [CNT_W-1:0] i_fill,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic             i_remove,
    input  logic [AGE_W-1:0] i_tgt,
    input  t_link            i_left,
    input  logic [AGE_W-1:0] i_left_age,
    input  t_sample          i_right_data,
    input  logic [AGE_W-1:0] i_right_age,
    output t_link            o_link,
    output logic [AGE_W-1:0] o_age,
    output logic [AGE_W-1:0] o_cur_age,
    output t_sample          o_data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    t_sample          r_data, n_data;
    logic [AGE_W-1:0] r_age, n_age;
    logic             valid, match, del, gt;
    t_sample          rd;
    logic [AGE_W-1:0] ra;

    always_comb begin
        valid = MY_IDX < i_fill;
        match = i_remove && valid && (r_age == i_tgt);
        del   = i_left.del || match;
        // close the gap left by the dropped entry
        rd    = del ? i_right_data : r_data;
        ra    = del ? i_right_age  : r_age;
        gt    = (MY_IDX >= i_cnt) || (rd > i_sample);
        if (i_left.gt) begin
            n_data = i_left.data;
            n_age  = i_left_age + AGE_W'(1);
        end else if (gt) begin
            n_data = i_sample;
            n_age  = '0;
        end else begin
            n_data = rd;
            n_age  = ra + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_data <= n_data;
            r_age  <= n_age;
        end
    end

    assign o_link    = '{del: del, gt: gt, data: rd};
    assign o_age     = ra;
    assign o_cur_age = r_age;
    assign o_data    = r_data;

endmodule

[rtl/core/swm_median.sv]
// Median pick from the sorted cells and the output register.
`timescale 1ns / 1ps
module swm_median import swm_pkg::*; #(
    parameter int MAX_WINDOW = 16,
    parameter int CNT_W      = 5
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  t_sample [MAX_WINDOW-1:0] i_vals,
    input  logic [CNT_W-1:0]         i_fill,
    output t_sample                  o_median
);

    t_sample                 r_med, n_med;
    logic [CNT_W-1:0]        mid, lo_idx;
    logic [SAMPLE_W-1:0]     hi, lo;
    logic signed [SAMPLE_W:0] sum, half;

    always_comb begin
        mid    = i_fill >> 1;
        // odd count: both picks land on the middle entry
        lo_idx = i_fill[0] ? mid : mid - CNT_W'(1);
        hi     = '0;
        lo     = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (CNT_W'(i) == mid)    hi = hi | i_vals[i];
            if (CNT_W'(i) == lo_idx) lo = lo | i_vals[i];
        end
        sum   = {hi[SAMPLE_W-1], hi} + {lo[SAMPLE_W-1], lo};
        // halve, truncating toward zero
        half  = (sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]}) >>> 1;
        n_med = half[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_med <= n_med;
        end
    end

    assign o_median = r_med;

endmodule

[bench/sliding_window_median_unit_tb.sv]
// Self-checking bench for the sliding window median unit: random stream with model check.
`timescale 1ns / 1ps
module sliding_window_median_unit_tb;
    import swm_pkg::*;

    localparam int MAXW = 16;

    typedef struct packed {
        t_sample sample;
        logic    restart;
    } t_smp_item;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY
    } t_stall;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    swm_smp_if smp ();
    swm_med_if med ();

    sliding_window_median_unit #(.MAX_WINDOW(MAXW)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_med   (med),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Window model: arrival ring plus ascending copy.
    t_sample     win_ring [MAXW];
    t_sample     win_sorted [MAXW];
    int unsigned win_fill;
    int unsigned win_oldest;
    t_win_size   win_size_reg;

    t_smp_item   smp_pending [$];
    t_sample     median_due [$];
    int          errors;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned results_seen;
    bit          long_hold_done;
    t_stall      stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void window_config(logic [APB_DW-1:0] value);
        win_size_reg = value[WS_W-1:0];
        win_fill     = 0;
        win_oldest   = 0;
    endfunction

    function automatic t_sample next_median(t_sample s, logic restart);
        int unsigned w;
        int unsigned pos;
        int unsigned j;
        int unsigned mid;
        t_sample     old;
        longint      acc;
        w = (win_size_reg == 0) ? 1 : ((win_size_reg > MAXW) ? MAXW : win_size_reg);
        if (restart) begin
            win_fill   = 0;
            win_oldest = 0;
        end
        if (win_fill < w) begin
            win_ring[win_fill] = s;
        end else begin
            if (win_oldest >= w) win_oldest = 0;
            old = win_ring[win_oldest];
            win_ring[win_oldest] = s;
            win_oldest++;
            if (win_oldest >= w) win_oldest = 0;
            // drop the first copy of the evicted sample
            pos = win_fill;
            for (j = 0; j < win_fill; j++)
                if (pos == win_fill && win_sorted[j] == old) pos = j;
            if (pos < win_fill) begin
                for (j = pos; j + 1 < win_fill; j++) win_sorted[j] = win_sorted[j + 1];
                win_fill--;
            end
        end
        pos = win_fill;
        while (pos > 0 && win_sorted[pos - 1] > s) begin
            win_sorted[pos] = win_sorted[pos - 1];
            pos--;
        end
        win_sorted[pos] = s;
        win_fill++;
        mid = win_fill / 2;
        if (win_fill % 2 == 0)
            acc = (longint'(win_sorted[mid]) + longint'(win_sorted[mid - 1])) / 2;
        else
            acc = longint'(win_sorted[mid]);
        return t_sample'(acc[SAMPLE_W-1:0]);
    endfunction

    function automatic t_smp_item rand_item(int unsigned restart_odds);
        t_smp_item it;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: it.sample = t_sample'(32'h7fff_ffff);
                    1: it.sample = t_sample'(32'h8000_0000);
                    2: it.sample = t_sample'(32'h7fff_fffe);
                    3: it.sample = t_sample'(32'h8000_0001);
                    4: it.sample = t_sample'(32'hffff_ffff);
                    default: it.sample = '0;
                endcase
            end
            // small values give plenty of duplicates in the window
            1, 2, 3: it.sample = t_sample'(int'($urandom_range(0, 8)) - 4);
            default: it.sample = t_sample'($urandom);
        endcase
        it.restart = ($urandom_range(0, restart_odds) == 0);
        return it;
    endfunction

    // Append one item to the pending queue.
    function automatic void add_pending(t_sample s, logic restart);
        t_smp_item it;
        it.sample  = s;
        it.restart = restart;
        smp_pending.insert(smp_pending.size(), it);
    endfunction

    task automatic queue_random(int unsigned count, int unsigned restart_odds);
        t_smp_item it;
        repeat (count) begin
            it = rand_item(restart_odds);
            add_pending(it.sample, it.restart);
        end
    endtask

    // Check at the falling edge, when driver and receiver updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (smp_pending.size() != 0 || smp.valid || median_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (t_reg_idx'(addr[2]) == REG_WINDOW_SIZE) window_config(data);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the window size, then read it back.
    task automatic set_window(t_win_size size);
        logic [APB_DW-1:0] data;
        logic [APB_DW-1:0] want;
        data            = $urandom;
        data[WS_W-1:0]  = size;
        want            = '0;
        want[WS_W-1:0]  = size;
        apb_write(APB_AW'(REG_WINDOW_SIZE) << 2, data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(REG_WINDOW_SIZE) << 2;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            errors++;
            $display("%0t: window size readback: expected %0d, actual %0d",
                     $time, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender: bursts of items with random gaps.
    always @(posedge i_clk) begin
        t_smp_item nxt;
        if (!i_rst_n) begin
            smp.valid   <= 1'b0;
            smp.sample  <= '0;
            smp.restart <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            if (smp.valid && smp.ready)
                median_due.insert(median_due.size(), next_median(smp.sample, smp.restart));
            if (!smp.valid || smp.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    smp.valid <= 1'b0;
                end else if (smp_pending.size() > 0) begin
                    nxt = smp_pending.pop_front();
                    smp.valid   <= 1'b1;
                    smp.sample  <= nxt.sample;
                    smp.restart <= nxt.restart;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each median, stall on a pattern of its own.
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            med.ready      <= 1'b0;
            hold_left      = 0;
            mode_left      = 0;
            results_seen   = 0;
            long_hold_done = 1'b0;
            stall_mode     = STALL_NONE;
        end else begin
            if (med.valid && med.ready) begin
                results_seen++;
                if (median_due.size() == 0) begin
                    errors++;
                    $display("%0t: median with none expected: expected none, actual %0d",
                             $time, med.median);
                end else begin
                    want = median_due.pop_front();
                    if (med.median !== want) begin
                        errors++;
                        $display("%0t: median mismatch: expected %0d, actual %0d",
                                 $time, want, med.median);
                    end
                end
            end
            // hold off long enough for the block to back up into its input
            if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                hold_left      = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                med.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall'($urandom_range(0, 2));
                    mode_left  = $urandom_range(16, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE: med.ready <= 1'b1;
                    STALL_HALF: med.ready <= $urandom_range(0, 1);
                    default:    med.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        smp.valid   = 1'b0;
        smp.sample  = '0;
        smp.restart = 1'b0;
        med.ready   = 1'b0;
        errors      = 0;
        win_size_reg = WS_RESET;
        win_fill     = 0;
        win_oldest   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first sample after reset, extremes, even-count rounding, duplicates
        add_pending(t_sample'(5), 1'b0);
        add_pending(t_sample'(32'h7fff_ffff), 1'b1);
        add_pending(t_sample'(32'h7fff_ffff), 1'b0);
        add_pending(t_sample'(32'h8000_0000), 1'b0);
        add_pending(t_sample'(32'h8000_0000), 1'b0);
        add_pending(t_sample'(32'h8000_0000), 1'b1);
        add_pending(t_sample'(32'h8000_0000), 1'b0);
        add_pending(t_sample'(-3), 1'b1);
        add_pending(t_sample'(0), 1'b0);
        add_pending(t_sample'(3), 1'b1);
        add_pending(t_sample'(0), 1'b0);
        add_pending(t_sample'(-1), 1'b1);
        add_pending(t_sample'(-2), 1'b0);
        add_pending(t_sample'(7), 1'b1);
        add_pending(t_sample'(7), 1'b0);
        add_pending(t_sample'(7), 1'b0);
        add_pending(t_sample'(-7), 1'b0);
        queue_random(8, 1000);
        wait_idle();

        // write to an unmapped address: window must carry on untouched
        apb_write(APB_AW'(4), $urandom);
        queue_random(40, 1000);
        wait_idle();

        set_window(5'd1);
        queue_random(50, 40);
        wait_idle();
        set_window(5'd0);
        queue_random(40, 40);
        wait_idle();
        set_window(5'd2);
        queue_random(50, 40);
        wait_idle();
        set_window(5'd16);
        queue_random(40, 60);
        wait_idle();
        // pause without a register write
        queue_random(30, 40);
        wait_idle();
        set_window(5'd31);
        queue_random(40, 60);
        wait_idle();
        set_window(5'd17);
        queue_random(40, 40);
        wait_idle();
        set_window(5'd3);
        queue_random(40, 30);
        wait_idle();
        set_window(5'd5);
        queue_random(40, 30);
        wait_idle();
        repeat (3) begin
            set_window(t_win_size'($urandom_range(1, 31)));
            queue_random(20, 40);
            wait_idle();
        end
        set_window(WS_RESET);
        queue_random(30, 1000);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_cell.sv
rtl/core/swm_median.sv
rtl/core/sliding_window_median_unit.sv
bench/sliding_window_median_unit_tb.sv
